/* sv/ccsm_pkg.sv */
// ----------------------------------------------------------------------------
// ccsm_pkg
// Shared types and character constants for the C comment/literal marker.
// ----------------------------------------------------------------------------
package ccsm_pkg;

	// Characters that steer the lexer
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;

	// Lexer mode
	typedef enum logic [2:0] {
		MODE_CODE  = 3'd0,
		MODE_LINE  = 3'd1,
		MODE_BLOCK = 3'd2,
		MODE_STR   = 3'd3,
		MODE_CHR   = 3'd4
	} lex_mode_t;

	// One marked byte
	typedef struct packed {
		logic       last;
		logic       keep;
		logic [7:0] ch;
	} mark_t;

	// Up to two marks caused by one input byte (cnt is 1 or 2 once queued)
	typedef struct packed {
		logic [1:0] cnt;
		mark_t      r1;
		mark_t      r0;
	} mark_pair_t;

endpackage

/* sv/ccsm_fifo.sv */
// ----------------------------------------------------------------------------
// ccsm_fifo
// Small synchronous queue between the lexer front end and the output back end.
// ----------------------------------------------------------------------------
module ccsm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [PW-1:0] PTR_ONE  = PW'(1);
	localparam logic [CW-1:0] CNT_ONE  = CW'(1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + PTR_ONE;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + PTR_ONE;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_ONE;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_ONE;
			end
		end
	end

endmodule

/* sv/ccsm_front.sv */
// ----------------------------------------------------------------------------
// ccsm_front
// Lexer front end: takes one byte per cycle while the queue has room, updates
// the lexer state and produces the zero, one or two marks the byte releases.
// ----------------------------------------------------------------------------
module ccsm_front import ccsm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] in_char,
	input  logic       in_eot,
	input  logic       q_full,
	output logic       in_ready,
	output logic       q_push,
	output mark_pair_t q_data
);

	lex_mode_t mode_q, mode_d;
	logic      esc_q, esc_d;
	logic      held_q, held_d;
	logic      star_q, star_d;

	mark_pair_t pair;
	mark_t      res;
	logic       emit, done;
	logic [7:0] quote;
	logic       accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;
	assign q_push   = accept && (pair.cnt != 2'd0);
	assign q_data   = pair;

	// next state and marks for the current byte
	always_comb begin
		mode_d = mode_q;
		esc_d  = esc_q;
		held_d = held_q;
		star_d = star_q;
		pair   = '0;
		res    = '0;
		emit   = 1'b0;
		done   = 1'b0;
		quote  = CH_DQUOTE;

		// resolve a slash held from the previous byte
		if (held_q) begin
			held_d = 1'b0;
			if (in_char == CH_SLASH || in_char == CH_STAR) begin
				pair.r0  = '{last: 1'b0, keep: 1'b0, ch: CH_SLASH};
				pair.r1  = '{last: 1'b0, keep: 1'b0, ch: in_char};
				pair.cnt = 2'd2;
				done     = 1'b1;
				if (in_char == CH_SLASH) begin
					mode_d = MODE_LINE;
				end else begin
					mode_d = MODE_BLOCK;
					star_d = 1'b0;
				end
			end else begin
				pair.r0  = '{last: 1'b0, keep: 1'b1, ch: CH_SLASH};
				pair.cnt = 2'd1;
				mode_d   = MODE_CODE;
			end
		end

		// byte in the current mode
		if (!done) begin
			res.ch = in_char;
			emit   = 1'b1;
			case (mode_d)
				MODE_LINE: begin
					res.keep = (in_char == CH_NL);
					if (in_char == CH_NL) begin
						mode_d = MODE_CODE;
					end
				end
				MODE_BLOCK: begin
					res.keep = 1'b0;
					if (star_q && in_char == CH_SLASH) begin
						mode_d = MODE_CODE;
						star_d = 1'b0;
					end else begin
						star_d = (in_char == CH_STAR);
					end
				end
				MODE_STR, MODE_CHR: begin
					res.keep = 1'b0;
					quote = (mode_d == MODE_STR) ? CH_DQUOTE : CH_SQUOTE;
					if (in_char == quote && !esc_q) begin
						mode_d = MODE_CODE;
					end else if (in_char == CH_BSLASH) begin
						esc_d = !esc_q;
					end else begin
						esc_d = 1'b0;
					end
				end
				default: begin
					mode_d = MODE_CODE;
					if (in_char == CH_DQUOTE) begin
						mode_d   = MODE_STR;
						esc_d    = 1'b0;
						res.keep = 1'b0;
					end else if (in_char == CH_SQUOTE) begin
						mode_d   = MODE_CHR;
						esc_d    = 1'b0;
						res.keep = 1'b0;
					end else if (in_char == CH_SLASH && !in_eot) begin
						held_d = 1'b1;
						emit   = 1'b0;
					end else begin
						res.keep = 1'b1;
					end
				end
			endcase

			if (emit) begin
				if (pair.cnt == 2'd0) begin
					pair.r0 = res;
				end else begin
					pair.r1 = res;
				end
				pair.cnt = pair.cnt + 2'd1;
			end
		end

		// end of text: flag the final mark and return to reset state
		if (in_eot) begin
			if (pair.cnt == 2'd2) begin
				pair.r1.last = 1'b1;
			end else begin
				pair.r0.last = 1'b1;
			end
			mode_d = MODE_CODE;
			esc_d  = 1'b0;
			held_d = 1'b0;
			star_d = 1'b0;
		end
	end

	// lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_CODE;
			esc_q  <= 1'b0;
			held_q <= 1'b0;
			star_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			esc_q  <= esc_d;
			held_q <= held_d;
			star_q <= star_d;
		end
	end

endmodule

/* sv/ccsm_back.sv */
// ----------------------------------------------------------------------------
// ccsm_back
// Output back end: pops mark pairs from the queue and sends their marks one
// request per cycle from an output register while out_ready is high.
// ----------------------------------------------------------------------------
module ccsm_back import ccsm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  mark_pair_t q_data,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output mark_t      out_mark
);

	mark_pair_t entry_q;
	logic       valid_q;
	logic       idx_q;
	logic       finish;

	// the current entry is done once its final mark is taken
	assign finish    = idx_q || (entry_q.cnt != 2'd2);
	assign q_pop     = !q_empty && (!valid_q || (out_ready && finish));
	assign out_valid = valid_q;
	assign out_mark  = idx_q ? entry_q.r1 : entry_q.r0;

	// payload register
	always_ff @(posedge clk) begin
		if (q_pop) begin
			entry_q <= q_data;
		end
	end

	// output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
			idx_q   <= 1'b0;
		end else if (valid_q && out_ready) begin
			if (finish) begin
				valid_q <= 1'b0;
				idx_q   <= 1'b0;
			end else begin
				idx_q <= 1'b1;
			end
		end
	end

endmodule

/* sv/c_comment_string_marker.sv */
// ----------------------------------------------------------------------------
// c_comment_string_marker
// Marks each byte of C source text as code or as comment/literal.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata    | tuser | tlast
//  --------+-----------+----------+-------+------------
//  s_*     | in        | char_in  | -     | end_of_text
//  m_*     | out       | char_out | keep  | last_out
//
//  The front end takes one byte every cycle while the queue has room; the
//  byte's marks reach the queue in the same cycle, then the output register.
//  The back end sends one mark per cycle while m_tready is high, so a byte
//  that releases two marks (slash pairs) takes two output transfers.
//  Reset (arst_n low) returns the lexer to code mode and empties the queue.
//  A stalled output fills the queue of DEPTH entries, then s_tready drops.
// ----------------------------------------------------------------------------
module c_comment_string_marker import ccsm_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_in
	input  logic       s_tlast,   // end_of_text
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] char_out
	output logic       m_tuser,   // [0] keep
	output logic       m_tlast    // last_out
);

	localparam int PW = $bits(mark_pair_t);

	mark_pair_t push_data, pop_data;
	logic [PW-1:0] pop_raw;
	logic push, pop, full, empty;
	mark_t mark;

	assign pop_data = mark_pair_t'(pop_raw);

	ccsm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_char  (s_tdata),
		.in_eot   (s_tlast),
		.q_full   (full),
		.in_ready (s_tready),
		.q_push   (push),
		.q_data   (push_data)
	);

	ccsm_fifo #(
		.WIDTH (PW),
		.DEPTH (DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (PW'(push_data)),
		.pop    (pop),
		.rdata  (pop_raw),
		.full   (full),
		.empty  (empty)
	);

	ccsm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (empty),
		.q_data    (pop_data),
		.q_pop     (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_mark  (mark)
	);

	assign m_tdata = mark.ch;
	assign m_tuser = mark.keep;
	assign m_tlast = mark.last;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream test of the C comment/literal marker. Source bytes go in on the
// slave side with random gaps; every accepted byte is run through a local
// model of the lexer, and the marks it must cause are queued and matched in
// order against the master side, which stalls at random.
// ----------------------------------------------------------------------------
module tb_top import ccsm_pkg::*; ();

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;   // [7:0] char_in
	logic       s_tlast  = 1'b0;    // end_of_text
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;            // [7:0] char_out
	logic       m_tuser;            // [0] keep
	logic       m_tlast;            // last_out

	c_comment_string_marker u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Lexer state as predicted from the accepted requests
	lex_mode_t  lx_mode  = MODE_CODE;
	logic       lx_esc   = 1'b0;
	logic       lx_held  = 1'b0;
	logic       lx_star  = 1'b0;

	mark_t      marks_due[$];       // marks still owed by the block
	int         n_err    = 0;
	int         n_sent   = 0;
	int         text_left = 40;     // bytes left in the current source text
	int         src_idle_pct = 36;
	int         snk_idle_pct = 36;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic mark_t mark_of(input logic k, input logic [7:0] c);
		mark_of = '{last: 1'b0, keep: k, ch: c};
	endfunction

	// Work out the marks one accepted byte causes and queue them
	task automatic mark_byte(input logic [7:0] c, input logic eot);
		mark_t      m[$];
		logic       done;
		logic [7:0] quote;
		done = 1'b0;
		// a slash held from the previous byte is settled first
		if (lx_held) begin
			lx_held = 1'b0;
			if (c == CH_SLASH || c == CH_STAR) begin
				m.push_back(mark_of(1'b0, CH_SLASH));
				m.push_back(mark_of(1'b0, c));
				if (c == CH_SLASH) begin
					lx_mode = MODE_LINE;
				end else begin
					lx_mode = MODE_BLOCK;
					lx_star = 1'b0;
				end
				done = 1'b1;
			end else begin
				m.push_back(mark_of(1'b1, CH_SLASH));
				lx_mode = MODE_CODE;
			end
		end
		if (!done) begin
			case (lx_mode)
				MODE_LINE: begin
					// the newline that ends the comment is code again
					if (c == CH_NL) begin
						m.push_back(mark_of(1'b1, c));
						lx_mode = MODE_CODE;
					end else begin
						m.push_back(mark_of(1'b0, c));
					end
				end
				MODE_BLOCK: begin
					if (lx_star && c == CH_SLASH) begin
						lx_mode = MODE_CODE;
						lx_star = 1'b0;
					end else begin
						lx_star = (c == CH_STAR);
					end
					m.push_back(mark_of(1'b0, c));
				end
				MODE_STR, MODE_CHR: begin
					quote = (lx_mode == MODE_STR) ? CH_DQUOTE : CH_SQUOTE;
					if (c == quote && !lx_esc) begin
						lx_mode = MODE_CODE;
					end else if (c == CH_BSLASH) begin
						lx_esc = ~lx_esc;
					end else begin
						lx_esc = 1'b0;
					end
					m.push_back(mark_of(1'b0, c));
				end
				default: begin
					lx_mode = MODE_CODE;
					if (c == CH_DQUOTE || c == CH_SQUOTE) begin
						lx_mode = (c == CH_DQUOTE) ? MODE_STR : MODE_CHR;
						lx_esc  = 1'b0;
						m.push_back(mark_of(1'b0, c));
					end else if (c == CH_SLASH) begin
						// a slash at the end of text cannot open a comment
						if (eot)
							m.push_back(mark_of(1'b1, c));
						else
							lx_held = 1'b1;
					end else begin
						m.push_back(mark_of(1'b1, c));
					end
				end
			endcase
		end
		// end of text: flag the final mark, back to plain code
		if (eot) begin
			if (m.size() > 0)
				m[m.size()-1].last = 1'b1;
			lx_mode = MODE_CODE;
			lx_esc  = 1'b0;
			lx_held = 1'b0;
			lx_star = 1'b0;
		end
		foreach (m[i])
			marks_due.push_back(m[i]);
	endtask

	// Send one request, with a random gap in front
	task automatic send_byte(input logic [7:0] c, input logic eot);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= eot;
		do @(posedge clk); while (!s_tready);
		mark_byte(c, eot);
		n_sent++;
	endtask

	task automatic send_text(input string s, input logic eot_last);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], eot_last && (i == s.len() - 1));
	endtask

	// Byte of a running source text; ends the text when its length is used up
	task automatic put_char(input logic [7:0] c);
		logic eot;
		eot = (text_left <= 1);
		send_byte(c, eot);
		if (eot)
			text_left = $urandom_range(1, 80);
		else
			text_left--;
	endtask

	function automatic logic [7:0] code_char();
		case ($urandom_range(7))
			0, 1:    code_char = 8'($urandom_range(32, 126));
			2:       code_char = CH_SLASH;
			3:       code_char = CH_STAR;
			4:       code_char = CH_NL;
			5:       code_char = CH_BSLASH;
			default: code_char = 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [7:0] body_char();
		case ($urandom_range(9))
			0:       body_char = CH_STAR;
			1:       body_char = CH_SLASH;
			2:       body_char = CH_BSLASH;
			3:       body_char = CH_DQUOTE;
			4:       body_char = CH_SQUOTE;
			5:       body_char = CH_NL;
			default: body_char = 8'($urandom_range(255));
		endcase
	endfunction

	// One lexical token, mostly well formed, sometimes plain noise
	task automatic send_token();
		int n;
		n = $urandom_range(0, 8);
		case ($urandom_range(9))
			0, 1, 2: put_char(code_char());
			3: begin
				put_char(CH_SLASH);
				put_char(CH_SLASH);
				repeat (n) put_char(body_char());
				put_char(CH_NL);
			end
			4: begin
				put_char(CH_SLASH);
				put_char(CH_STAR);
				repeat (n) put_char(body_char());
				put_char(CH_STAR);
				put_char(CH_SLASH);
			end
			5: begin
				put_char(CH_DQUOTE);
				repeat (n) put_char(body_char());
				put_char(CH_DQUOTE);
			end
			6: begin
				put_char(CH_SQUOTE);
				repeat (n % 3) put_char(body_char());
				put_char(CH_SQUOTE);
			end
			7: begin
				put_char(CH_SLASH);
				put_char(code_char());
			end
			default: put_char(8'($urandom_range(255)));
		endcase
	endtask

	task automatic wait_marks_done();
		s_tvalid <= 1'b0;
		while (marks_due.size() != 0)
			@(posedge clk);
	endtask

	// Output side: random stalls, each mark checked against the oldest one due
	always @(posedge clk) begin
		mark_t exp_m;
		if (arst_n && m_tvalid && m_tready) begin
			if (marks_due.size() == 0) begin
				$error("unexpected mark: char_out %h keep %b last_out %b",
					m_tdata, m_tuser, m_tlast);
				n_err++;
			end else begin
				exp_m = marks_due.pop_front();
				if (m_tdata !== exp_m.ch) begin
					$error("char_out: expected %h, got %h", exp_m.ch, m_tdata);
					n_err++;
				end
				if (m_tuser !== exp_m.keep) begin
					$error("keep: expected %b, got %b", exp_m.keep, m_tuser);
					n_err++;
				end
				if (m_tlast !== exp_m.last) begin
					$error("last_out: expected %b, got %b", exp_m.last, m_tlast);
					n_err++;
				end
			end
		end
		m_tready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// Extremes and each lexer corner case
	task automatic test_directed();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		// held slash released by a quote, then a string with escapes
		send_text("/\"\\\"\\\\\"", 1'b0);
		// char literal holding an escaped quote
		send_text("'\\''", 1'b0);
		// the opening star must not close the block comment
		send_text("/*/*/", 1'b0);
		// line comment; its newline is code
		send_text("//", 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(CH_NL, 1'b0);
		// slash at end of text is kept at once
		send_byte(CH_SLASH, 1'b1);
		// comment left open at end of text
		send_text("/*", 1'b1);
	endtask

	task automatic test_lexer_random(input int count);
		int stop_at;
		stop_at = n_sent + count;
		while (n_sent < stop_at)
			send_token();
	endtask

	// Both sides at full rate
	task automatic test_full_rate(input int count);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_lexer_random(count);
		src_idle_pct = 36;
		snk_idle_pct = 36;
	endtask

	// Sender holds off until the output side has caught up
	task automatic test_drain_pause();
		test_lexer_random(100);
		wait_marks_done();
		test_lexer_random(100);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_lexer_random(900);
		test_drain_pause();
		test_full_rate(300);
		test_lexer_random(250);
		wait_marks_done();
		repeat (20) @(posedge clk);
		if (n_err == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
